// ===== rtl/fse_pkg.sv =====
// shared constants, opcode codes and decode tables for the forth stack engine
package fse_pkg;

    localparam int CELL_W   = 32;
    localparam int ACT_W    = 6;
    localparam int FAULT_W  = 3;
    localparam int DEPTH_W  = 6;
    localparam int DICT_W   = 12;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_DATA_STACK_DEPTH   = 32;
    localparam int DEF_RETURN_STACK_DEPTH = 32;
    localparam int DEF_MEM_WORDS          = 1024;

    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [ACT_W-1:0] act_t;
    typedef logic [FAULT_W-1:0] fault_t;

    localparam logic [CFG_IDX_W-1:0] CFG_START_ADDRESS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DICTIONARY_START = 1'd1;

    localparam act_t A_EXIT     = 6'd0;
    localparam act_t A_DUP      = 6'd1;
    localparam act_t A_2DUP     = 6'd2;
    localparam act_t A_DROP     = 6'd3;
    localparam act_t A_OVER     = 6'd4;
    localparam act_t A_SWAP     = 6'd5;
    localparam act_t A_ROT      = 6'd6;
    localparam act_t A_ADD      = 6'd7;
    localparam act_t A_SUB      = 6'd8;
    localparam act_t A_MUL      = 6'd9;
    localparam act_t A_DIV      = 6'd10;
    localparam act_t A_MOD      = 6'd11;
    localparam act_t A_EQ       = 6'd12;
    localparam act_t A_LT       = 6'd13;
    localparam act_t A_LE       = 6'd14;
    localparam act_t A_GT       = 6'd15;
    localparam act_t A_GE       = 6'd16;
    localparam act_t A_ZEQ      = 6'd17;
    localparam act_t A_ZGT      = 6'd18;
    localparam act_t A_ZGE      = 6'd19;
    localparam act_t A_ZLT      = 6'd20;
    localparam act_t A_ZLE      = 6'd21;
    localparam act_t A_LIT      = 6'd22;
    localparam act_t A_JZ       = 6'd23;
    localparam act_t A_TOR      = 6'd24;
    localparam act_t A_FROMR    = 6'd25;
    localparam act_t A_FETCH    = 6'd26;
    localparam act_t A_STORE    = 6'd27;
    localparam act_t A_CFETCH   = 6'd28;
    localparam act_t A_CSTORE   = 6'd29;
    localparam act_t A_DUPPLUS  = 6'd30;
    localparam act_t A_OVERPLUS = 6'd31;
    localparam act_t A_COMMA    = 6'd32;

    localparam fault_t F_NONE       = 3'd0;
    localparam fault_t F_DUNDERFLOW = 3'd1;
    localparam fault_t F_DOVERFLOW  = 3'd2;
    localparam fault_t F_RUNDERFLOW = 3'd3;
    localparam fault_t F_ROVERFLOW  = 3'd4;
    localparam fault_t F_DIVZERO    = 3'd5;

    // data stack entries an action needs, top included
    function automatic logic [1:0] need_of(input act_t act);
        logic [1:0] n;
        case (act)
            A_EXIT, A_LIT, A_FROMR:                          n = 2'd0;
            A_DUP, A_DROP, A_ZEQ, A_ZGT, A_ZGE, A_ZLT, A_ZLE,
            A_JZ, A_TOR, A_FETCH, A_CFETCH, A_DUPPLUS, A_COMMA: n = 2'd1;
            A_ROT:                                           n = 2'd3;
            default:                                         n = 2'd2;
        endcase
        return n;
    endfunction

    // positive growth of the data stack, zero for shrinking actions
    function automatic logic [1:0] grow_of(input act_t act);
        logic [1:0] g;
        case (act)
            A_DUP, A_OVER, A_LIT, A_FROMR, A_DUPPLUS, A_OVERPLUS: g = 2'd1;
            A_2DUP:                                               g = 2'd2;
            default:                                              g = 2'd0;
        endcase
        return g;
    endfunction

    function automatic logic is_mem_op(input act_t act);
        return (act == A_FETCH) || (act == A_STORE) || (act == A_CFETCH) ||
               (act == A_CSTORE) || (act == A_COMMA);
    endfunction

endpackage

// ===== rtl/fse_ram.sv =====
// generic single write port ram with registered read
module fse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/fse_divider.sv =====
// unsigned restoring divider, one quotient bit per cycle
module fse_divider (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  fse_pkg::cell_t dividend,
    input  fse_pkg::cell_t divisor,
    output logic          done,
    output fse_pkg::cell_t quotient,
    output fse_pkg::cell_t remainder
);

    localparam int W  = fse_pkg::CELL_W;
    localparam int CNW = $clog2(W + 1);

    logic [W-1:0]   quo_reg;
    logic [W-1:0]   rem_reg;
    logic [W-1:0]   dvs_reg;
    logic [CNW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [W:0]     trial;

    assign trial = {rem_reg, quo_reg[W-1]} - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= CNW'(W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!trial[W])
                begin
                    rem_reg <= trial[W-1:0];
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[W-2:0], quo_reg[W-1]};
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - CNW'(1);
                if (cnt_reg == CNW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/forth_stack_engine.sv =====
// forth primitive engine: stack, return stack and data memory around a sequencer
//
// Input channel (in_valid/in_ready) takes one primitive: action and inline_cell.
// Output channel (out_valid/out_ready) gives one result item per primitive:
// next_address, top_out, depth_out and fault.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) loads the
// instruction pointer (index 0) or the dictionary pointer (index 1); it is
// ready while the sequencer is idle and is written only while no primitive is in flight.
// Each item walks the sequencer: two data/return stack reads, decode and fault
// check, an optional data memory read, execute with write back, then the
// result register; a faulted item skips from the check to the result, and
// 2dup, rot and overplus add a second stack write step. Divide and modulo
// wait in S_DIV on a one-bit-per-cycle divider; memory primitives pass
// through S_RED1, S_RED2 and S_RED3 when MEM_WORDS is not a power of two, since
// the word index is then reduced by a reciprocal multiply and one correction.
// A new item is taken while a finished result still waits in the output
// register; the sequencer then holds at its last step until out_ready.
// Reset empties both stacks, zeroes top, instruction and dictionary pointers.
// Stack and data memory contents are not cleared.
module forth_stack_engine #(
    parameter int DATA_STACK_DEPTH   = fse_pkg::DEF_DATA_STACK_DEPTH,
    parameter int RETURN_STACK_DEPTH = fse_pkg::DEF_RETURN_STACK_DEPTH,
    parameter int MEM_WORDS          = fse_pkg::DEF_MEM_WORDS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [fse_pkg::ACT_W-1:0]           action,
    input  logic signed [fse_pkg::CELL_W-1:0]   inline_cell,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fse_pkg::CELL_W-1:0]          next_address,
    output logic signed [fse_pkg::CELL_W-1:0]   top_out,
    output logic [fse_pkg::DEPTH_W-1:0]         depth_out,
    output logic [fse_pkg::FAULT_W-1:0]         fault,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fse_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fse_pkg::CELL_W-1:0]          cfg_data
);

    localparam int CW   = $clog2(DATA_STACK_DEPTH + 2);
    localparam int DAW  = $clog2(DATA_STACK_DEPTH);
    localparam int RCW  = $clog2(RETURN_STACK_DEPTH + 1);
    localparam int RAW  = $clog2(RETURN_STACK_DEPTH);
    localparam int DMW  = $clog2(MEM_WORDS);
    localparam int W    = fse_pkg::CELL_W;
    localparam int DW   = fse_pkg::DICT_W;
    localparam bit MEM_POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
    localparam logic [W-1:0] RECIP = W'((1 << 30) / MEM_WORDS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD_S = 4'd1;
    localparam logic [3:0] S_RD_U = 4'd2;
    localparam logic [3:0] S_PREP = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_MEM  = 4'd5;
    localparam logic [3:0] S_EXEC = 4'd6;
    localparam logic [3:0] S_W2   = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_RED1 = 4'd9;
    localparam logic [3:0] S_RED2 = 4'd10;
    localparam logic [3:0] S_RED3 = 4'd11;

    logic [3:0]            state_reg;
    fse_pkg::act_t         op_reg;
    logic [W-1:0]          cell_reg;
    logic [W-1:0]          top_reg;
    logic [CW-1:0]         count_reg;
    logic [RCW-1:0]        rc_reg;
    logic [W-1:0]          ip_reg;
    logic [DW-1:0]         dp_reg;
    logic [W-1:0]          s_reg;
    logic [W-1:0]          u_reg;
    logic [W-1:0]          r_reg;
    fse_pkg::fault_t       fault_reg;
    logic [DMW-1:0]        idx_reg;
    logic [DAW-1:0]        w2_addr_reg;
    logic [W-1:0]          w2_data_reg;
    logic                  out_valid_reg;
    logic [W-1:0]          out_ip_reg;
    logic [W-1:0]          out_top_reg;
    logic [fse_pkg::DEPTH_W-1:0] out_depth_reg;
    fse_pkg::fault_t       out_fault_reg;
    logic [W-1:0]          red_q_reg;
    logic [W-1:0]          red_r_reg;

    logic [CW-1:0]  cnt_m1;
    logic [CW-1:0]  cnt_m2;
    logic [CW-1:0]  cnt_m3;
    logic [RCW-1:0] rc_m1;

    logic [DAW-1:0] ds_raddr;
    logic [DAW-1:0] ds_waddr;
    logic [W-1:0]   ds_wdata;
    logic [W-1:0]   ds_rdata;
    logic           ds_we;
    logic [W-1:0]   rs_rdata;
    logic           rs_we;
    logic [W-1:0]   dm_rdata;
    logic           dm_we;

    logic           div_start;
    logic [W-1:0]   div_dividend;
    logic [W-1:0]   div_divisor;
    logic           div_done;
    logic [W-1:0]   div_q;
    logic [W-1:0]   div_r;

    fse_pkg::fault_t fault_calc;
    logic [W-1:0]    mem_byte_addr;
    logic [W-1:0]    mem_word;
    logic [2*W-1:0]  red_prod;
    logic [W-1:0]    red_diff;
    logic [DMW-1:0]  red_idx;
    logic            out_load;

    // execute step results
    logic [W-1:0]   ex_top;
    logic [CW-1:0]  ex_count;
    logic [RCW-1:0] ex_rc;
    logic [W-1:0]   ex_ip;
    logic [DW-1:0]  ex_dp;
    logic           ex_w1;
    logic [DAW-1:0] ex_w1_addr;
    logic [W-1:0]   ex_w1_data;
    logic           ex_w2;
    logic [DAW-1:0] ex_w2_addr;
    logic [W-1:0]   ex_w2_data;
    logic           ex_rs_we;
    logic           ex_dm_we;
    logic [W-1:0]   ex_dm_data;

    logic           s_lt_t;
    logic           t_lt_s;
    logic           t_neg;
    logic           t_pos;
    logic [4:0]     lane_shift;
    logic [W-1:0]   byte_mask;

    assign cnt_m1 = count_reg - CW'(1);
    assign cnt_m2 = count_reg - CW'(2);
    assign cnt_m3 = count_reg - CW'(3);
    assign rc_m1  = rc_reg - RCW'(1);

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    // fault check, first matching code wins
    always_comb
    begin
        fault_calc = fse_pkg::F_NONE;
        if (op_reg <= fse_pkg::A_COMMA)
        begin
            if (32'(count_reg) < 32'(fse_pkg::need_of(op_reg)))
            begin
                fault_calc = fse_pkg::F_DUNDERFLOW;
            end
            else if (32'(count_reg) + 32'(fse_pkg::grow_of(op_reg)) >
                     32'(DATA_STACK_DEPTH + 1))
            begin
                fault_calc = fse_pkg::F_DOVERFLOW;
            end
            else if ((op_reg == fse_pkg::A_EXIT || op_reg == fse_pkg::A_FROMR) &&
                     rc_reg == '0)
            begin
                fault_calc = fse_pkg::F_RUNDERFLOW;
            end
            else if (op_reg == fse_pkg::A_TOR &&
                     32'(rc_reg) >= 32'(RETURN_STACK_DEPTH))
            begin
                fault_calc = fse_pkg::F_ROVERFLOW;
            end
            else if ((op_reg == fse_pkg::A_DIV || op_reg == fse_pkg::A_MOD) &&
                     top_reg == '0)
            begin
                fault_calc = fse_pkg::F_DIVZERO;
            end
        end
    end

    assign mem_byte_addr = (op_reg == fse_pkg::A_COMMA) ? W'(dp_reg) : top_reg;
    assign mem_word      = mem_byte_addr >> 2;

    // word index reduction: estimate quotient, subtract, one correction step
    assign red_prod = (2*W)'(mem_word) * (2*W)'(RECIP);
    assign red_diff = mem_word - red_q_reg * W'(MEM_WORDS);
    assign red_idx  = (red_r_reg >= W'(MEM_WORDS)) ? DMW'(red_r_reg - W'(MEM_WORDS))
                                                   : red_r_reg[DMW-1:0];

    // divider start: signed divide on magnitudes
    always_comb
    begin
        div_dividend = s_reg[W-1] ? (W'(0) - s_reg) : s_reg;
        div_divisor  = top_reg[W-1] ? (W'(0) - top_reg) : top_reg;
        div_start    = (state_reg == S_PREP) && (fault_calc == fse_pkg::F_NONE) &&
                       (op_reg == fse_pkg::A_DIV || op_reg == fse_pkg::A_MOD);
    end

    assign s_lt_t     = $signed(s_reg) < $signed(top_reg);
    assign t_lt_s     = $signed(top_reg) < $signed(s_reg);
    assign t_neg      = top_reg[W-1];
    assign t_pos      = !top_reg[W-1] && (top_reg != '0);
    assign lane_shift = {top_reg[1:0], 3'b000};
    assign byte_mask  = W'(8'hFF) << lane_shift;

    always_comb
    begin
        ex_top     = top_reg;
        ex_count   = count_reg;
        ex_rc      = rc_reg;
        ex_ip      = ip_reg + W'(4);
        ex_dp      = dp_reg;
        ex_w1      = 1'b0;
        ex_w1_addr = cnt_m1[DAW-1:0];
        ex_w1_data = top_reg;
        ex_w2      = 1'b0;
        ex_w2_addr = count_reg[DAW-1:0];
        ex_w2_data = s_reg;
        ex_rs_we   = 1'b0;
        ex_dm_we   = 1'b0;
        ex_dm_data = s_reg;
        case (op_reg)
            fse_pkg::A_EXIT:
            begin
                ex_rc = rc_m1;
                ex_ip = r_reg;
            end
            fse_pkg::A_DUP:
            begin
                ex_w1    = 1'b1;
                ex_count = count_reg + CW'(1);
            end
            fse_pkg::A_2DUP:
            begin
                ex_w1    = 1'b1;
                ex_w2    = 1'b1;
                ex_count = count_reg + CW'(2);
            end
            fse_pkg::A_DROP:
            begin
                ex_top   = s_reg;
                ex_count = cnt_m1;
            end
            fse_pkg::A_OVER:
            begin
                ex_w1    = 1'b1;
                ex_top   = s_reg;
                ex_count = count_reg + CW'(1);
            end
            fse_pkg::A_SWAP:
            begin
                ex_w1      = 1'b1;
                ex_w1_addr = cnt_m2[DAW-1:0];
                ex_top     = s_reg;
            end
            fse_pkg::A_ROT:
            begin
                ex_w1      = 1'b1;
                ex_w1_addr = cnt_m3[DAW-1:0];
                ex_w1_data = s_reg;
                ex_w2      = 1'b1;
                ex_w2_addr = cnt_m2[DAW-1:0];
                ex_w2_data = top_reg;
                ex_top     = u_reg;
            end
            fse_pkg::A_ADD:
            begin
                ex_top   = s_reg + top_reg;
                ex_count = cnt_m1;
            end
            fse_pkg::A_SUB:
            begin
                ex_top   = s_reg - top_reg;
                ex_count = cnt_m1;
            end
            fse_pkg::A_MUL:
            begin
                ex_top   = s_reg * top_reg;
                ex_count = cnt_m1;
            end
            fse_pkg::A_DIV:
            begin
                ex_top   = (s_reg[W-1] ^ top_reg[W-1]) ? (W'(0) - div_q) : div_q;
                ex_count = cnt_m1;
            end
            fse_pkg::A_MOD:
            begin
                ex_top   = s_reg[W-1] ? (W'(0) - div_r) : div_r;
                ex_count = cnt_m1;
            end
            fse_pkg::A_EQ:
            begin
                ex_top   = W'(s_reg == top_reg);
                ex_count = cnt_m1;
            end
            fse_pkg::A_LT:
            begin
                ex_top   = W'(s_lt_t);
                ex_count = cnt_m1;
            end
            fse_pkg::A_LE:
            begin
                ex_top   = W'(!t_lt_s);
                ex_count = cnt_m1;
            end
            fse_pkg::A_GT:
            begin
                ex_top   = W'(t_lt_s);
                ex_count = cnt_m1;
            end
            fse_pkg::A_GE:
            begin
                ex_top   = W'(!s_lt_t);
                ex_count = cnt_m1;
            end
            fse_pkg::A_ZEQ: ex_top = W'(top_reg == '0);
            fse_pkg::A_ZGT: ex_top = W'(t_pos);
            fse_pkg::A_ZGE: ex_top = W'(!t_neg);
            fse_pkg::A_ZLT: ex_top = W'(t_neg);
            fse_pkg::A_ZLE: ex_top = W'(!t_pos);
            fse_pkg::A_LIT:
            begin
                ex_w1    = (count_reg != '0);
                ex_top   = cell_reg;
                ex_count = count_reg + CW'(1);
                ex_ip    = ip_reg + W'(8);
            end
            fse_pkg::A_JZ:
            begin
                ex_ip = (top_reg != '0) ? (ip_reg + W'(8)) : cell_reg;
            end
            fse_pkg::A_TOR:
            begin
                ex_rs_we = 1'b1;
                ex_rc    = rc_reg + RCW'(1);
                ex_top   = s_reg;
                ex_count = cnt_m1;
            end
            fse_pkg::A_FROMR:
            begin
                ex_w1    = (count_reg != '0);
                ex_top   = r_reg;
                ex_count = count_reg + CW'(1);
                ex_rc    = rc_m1;
            end
            fse_pkg::A_FETCH: ex_top = dm_rdata;
            fse_pkg::A_STORE:
            begin
                ex_dm_we = 1'b1;
                ex_top   = u_reg;
                ex_count = count_reg - CW'(2);
            end
            fse_pkg::A_CFETCH:
            begin
                ex_top = W'(8'(dm_rdata >> lane_shift));
            end
            fse_pkg::A_CSTORE:
            begin
                ex_dm_we   = 1'b1;
                ex_dm_data = (dm_rdata & ~byte_mask) | (W'(s_reg[7:0]) << lane_shift);
                ex_top     = u_reg;
                ex_count   = count_reg - CW'(2);
            end
            fse_pkg::A_DUPPLUS:
            begin
                ex_w1      = 1'b1;
                ex_w1_data = top_reg + W'(1);
                ex_count   = count_reg + CW'(1);
            end
            fse_pkg::A_OVERPLUS:
            begin
                ex_w1      = 1'b1;
                ex_w1_addr = cnt_m2[DAW-1:0];
                ex_w1_data = s_reg + W'(1);
                ex_w2      = 1'b1;
                ex_w2_addr = cnt_m1[DAW-1:0];
                ex_w2_data = top_reg;
                ex_top     = s_reg;
                ex_count   = count_reg + CW'(1);
            end
            fse_pkg::A_COMMA:
            begin
                ex_dm_we   = 1'b1;
                ex_dm_data = top_reg;
                ex_dp      = dp_reg + DW'(4);
                ex_top     = s_reg;
                ex_count   = cnt_m1;
            end
            default:
            begin
                ex_top = top_reg;
            end
        endcase
    end

    // memory port control
    always_comb
    begin
        ds_raddr = cnt_m2[DAW-1:0];
        if (state_reg == S_RD_U)
        begin
            ds_raddr = cnt_m3[DAW-1:0];
        end
    end

    assign ds_we    = (state_reg == S_EXEC && ex_w1) || (state_reg == S_W2);
    assign ds_waddr = (state_reg == S_W2) ? w2_addr_reg : ex_w1_addr;
    assign ds_wdata = (state_reg == S_W2) ? w2_data_reg : ex_w1_data;
    assign rs_we    = (state_reg == S_EXEC) && ex_rs_we;
    assign dm_we    = (state_reg == S_EXEC) && ex_dm_we;

    fse_ram #(
        .WIDTH (W),
        .DEPTH (DATA_STACK_DEPTH)
    ) u_data_stack (
        .clk   (clk),
        .we    (ds_we),
        .waddr (ds_waddr),
        .wdata (ds_wdata),
        .raddr (ds_raddr),
        .rdata (ds_rdata)
    );

    fse_ram #(
        .WIDTH (W),
        .DEPTH (RETURN_STACK_DEPTH)
    ) u_return_stack (
        .clk   (clk),
        .we    (rs_we),
        .waddr (rc_reg[RAW-1:0]),
        .wdata (top_reg),
        .raddr (rc_m1[RAW-1:0]),
        .rdata (rs_rdata)
    );

    fse_ram #(
        .WIDTH (W),
        .DEPTH (MEM_WORDS)
    ) u_data_mem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (idx_reg),
        .wdata (ex_dm_data),
        .raddr (idx_reg),
        .rdata (dm_rdata)
    );

    fse_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            cell_reg      <= '0;
            top_reg       <= '0;
            count_reg     <= '0;
            rc_reg        <= '0;
            ip_reg        <= '0;
            dp_reg        <= '0;
            s_reg         <= '0;
            u_reg         <= '0;
            r_reg         <= '0;
            fault_reg     <= fse_pkg::F_NONE;
            idx_reg       <= '0;
            w2_addr_reg   <= '0;
            w2_data_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_ip_reg    <= '0;
            out_top_reg   <= '0;
            out_depth_reg <= '0;
            out_fault_reg <= fse_pkg::F_NONE;
            red_q_reg     <= '0;
            red_r_reg     <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == fse_pkg::CFG_START_ADDRESS)
                begin
                    ip_reg <= cfg_data;
                end
                else
                begin
                    dp_reg <= cfg_data[DW-1:0];
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= action;
                        cell_reg  <= inline_cell;
                        state_reg <= S_RD_S;
                    end
                end
                S_RD_S:
                begin
                    state_reg <= S_RD_U;
                end
                S_RD_U:
                begin
                    // second entry and return top arrive from the rams
                    s_reg     <= (count_reg >= CW'(2)) ? ds_rdata : '0;
                    r_reg     <= rs_rdata;
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    u_reg     <= (count_reg >= CW'(3)) ? ds_rdata : '0;
                    fault_reg <= fault_calc;
                    idx_reg   <= mem_word[DMW-1:0];
                    if (fault_calc != fse_pkg::F_NONE)
                    begin
                        state_reg <= S_FIN;
                    end
                    else if (div_start)
                    begin
                        state_reg <= S_DIV;
                    end
                    else if (fse_pkg::is_mem_op(op_reg))
                    begin
                        state_reg <= MEM_POW2 ? S_MEM : S_RED1;
                    end
                    else
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_RED1:
                begin
                    red_q_reg <= red_prod[W+29:30];
                    state_reg <= S_RED2;
                end
                S_RED2:
                begin
                    red_r_reg <= red_diff;
                    state_reg <= S_RED3;
                end
                S_RED3:
                begin
                    idx_reg   <= red_idx;
                    state_reg <= S_MEM;
                end
                S_MEM:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    top_reg     <= ex_top;
                    count_reg   <= ex_count;
                    rc_reg      <= ex_rc;
                    ip_reg      <= ex_ip;
                    dp_reg      <= ex_dp;
                    w2_addr_reg <= ex_w2_addr;
                    w2_data_reg <= ex_w2_data;
                    state_reg   <= ex_w2 ? S_W2 : S_FIN;
                end
                S_W2:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_load)
                    begin
                        out_ip_reg    <= ip_reg;
                        out_top_reg   <= (count_reg == '0) ? '0 : top_reg;
                        out_depth_reg <= fse_pkg::DEPTH_W'(count_reg);
                        out_fault_reg <= fault_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_address = out_ip_reg;
    assign top_out      = $signed(out_top_reg);
    assign depth_out    = out_depth_reg;
    assign fault        = out_fault_reg;

endmodule
